@@ hdl/hcbd_pkg.sv @@
package hcbd_pkg;

   localparam int COUNT_BITS_DEF = 64;

   localparam logic [15:0] TRAILER_LIMIT_RESET = 16'd4096;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_DEL   = 8'h7F;

   typedef enum logic [3:0] {
      PH_START   = 4'd0,
      PH_SIZE    = 4'd1,
      PH_EXT     = 4'd2,
      PH_SIZE_LF = 4'd3,
      PH_END_CR  = 4'd4,
      PH_END_LF  = 4'd5,
      PH_DATA    = 4'd6,
      PH_TR_NAME = 4'd7,
      PH_TR_VAL  = 4'd8,
      PH_TR_LF   = 4'd9,
      PH_ERROR   = 4'd10,
      PH_DONE    = 4'd11
   } phase_type;

   typedef enum logic [2:0] {
      K_FRAMING  = 3'd0,
      K_PAYLOAD  = 3'd1,
      K_COMPLETE = 3'd2,
      K_ERROR    = 3'd3,
      K_IGN_ERR  = 3'd4,
      K_IGN_DONE = 3'd5
   } kind_type;

   // parser control state
   typedef struct packed {
      phase_type phase;
      logic      term;
   } ctl_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  payload_byte;
   } result_type;

   // {valid, value}
   function automatic logic [4:0] hex_value(input logic [7:0] ch);
      logic [7:0] lc;
      logic [7:0] off;
      lc = ch | CH_SPACE;
      off = 8'h00;
      hex_value = 5'h00;
      if (ch inside {[8'h30:8'h39]}) begin
         off = ch - 8'h30;
         hex_value = {1'b1, off[3:0]};
      end else if (lc inside {[8'h61:8'h66]}) begin
         off = lc - 8'h57;
         hex_value = {1'b1, off[3:0]};
      end
   endfunction

   function automatic logic is_tchar(input logic [7:0] ch);
      logic [7:0] lc;
      lc = ch | CH_SPACE;
      is_tchar = (ch inside {[8'h30:8'h39]}) || (lc inside {[8'h61:8'h7A]}) ||
                 (ch inside {8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
                             8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E});
   endfunction

endpackage

@@ hdl/hcbd_step.sv @@
module hcbd_step #(
   parameter int COUNT_BITS = hcbd_pkg::COUNT_BITS_DEF
) (
   input  hcbd_pkg::ctl_type    ctl,
   input  logic [COUNT_BITS-1:0] count,
   input  logic [15:0]          trailer_limit,
   input  logic                 op,
   input  logic [7:0]           ch,
   output hcbd_pkg::ctl_type    ctl_in,
   output logic [COUNT_BITS-1:0] count_in,
   output hcbd_pkg::result_type rsp
);

   logic [4:0]            hex;
   logic                  tchar;
   logic [COUNT_BITS-1:0] trl_cnt;
   logic                  trl_ok;
   logic [COUNT_BITS-1:0] dec;
   logic                  bad;

   assign hex     = hcbd_pkg::hex_value(ch);
   assign tchar   = hcbd_pkg::is_tchar(ch);
   assign trl_cnt = count + COUNT_BITS'(1);
   assign trl_ok  = (trl_cnt <= COUNT_BITS'(trailer_limit));
   assign dec     = count - COUNT_BITS'(1);

   // next state
   always_comb begin
      ctl_in   = ctl;
      count_in = count;
      bad      = 1'b0;
      if (op) begin
         ctl_in.phase = hcbd_pkg::PH_START;
         ctl_in.term  = 1'b0;
         count_in     = '0;
      end else begin
         case (ctl.phase)
            hcbd_pkg::PH_START: begin
               if (!hex[4]) begin
                  bad = 1'b1;
               end else begin
                  count_in     = COUNT_BITS'(hex[3:0]);
                  ctl_in.phase = hcbd_pkg::PH_SIZE;
               end
            end
            hcbd_pkg::PH_SIZE: begin
               if (hex[4]) begin
                  // another digit only while the top nibble is still clear
                  if (count[COUNT_BITS-1 -: 4] == 4'h0) begin
                     count_in = {count[COUNT_BITS-5:0], hex[3:0]};
                  end else begin
                     bad = 1'b1;
                  end
               end else if (ch == hcbd_pkg::CH_CR) begin
                  ctl_in.phase = hcbd_pkg::PH_SIZE_LF;
               end else if (ch == hcbd_pkg::CH_SEMI) begin
                  ctl_in.phase = hcbd_pkg::PH_EXT;
               end else begin
                  bad = 1'b1;
               end
            end
            hcbd_pkg::PH_EXT: begin
               if (ch == hcbd_pkg::CH_CR) begin
                  ctl_in.phase = hcbd_pkg::PH_SIZE_LF;
               end
            end
            hcbd_pkg::PH_SIZE_LF: begin
               if (ch != hcbd_pkg::CH_LF) begin
                  bad = 1'b1;
               end else if (count != '0) begin
                  ctl_in.phase = hcbd_pkg::PH_DATA;
               end else begin
                  ctl_in.term  = 1'b1;
                  ctl_in.phase = hcbd_pkg::PH_END_CR;
               end
            end
            hcbd_pkg::PH_DATA: begin
               count_in = dec;
               if (dec == '0) begin
                  ctl_in.phase = hcbd_pkg::PH_END_CR;
               end
            end
            hcbd_pkg::PH_END_CR: begin
               if (ch == hcbd_pkg::CH_CR) begin
                  ctl_in.phase = hcbd_pkg::PH_END_LF;
               end else if (ctl.term && tchar && trl_ok) begin
                  count_in     = trl_cnt;
                  ctl_in.phase = hcbd_pkg::PH_TR_NAME;
               end else begin
                  bad = 1'b1;
               end
            end
            hcbd_pkg::PH_END_LF: begin
               if (ch != hcbd_pkg::CH_LF) begin
                  bad = 1'b1;
               end else if (!ctl.term) begin
                  ctl_in.phase = hcbd_pkg::PH_START;
               end else begin
                  ctl_in.phase = hcbd_pkg::PH_DONE;
               end
            end
            hcbd_pkg::PH_TR_NAME: begin
               if (ch == hcbd_pkg::CH_COLON) begin
                  ctl_in.phase = hcbd_pkg::PH_TR_VAL;
               end else if (!tchar) begin
                  bad = 1'b1;
               end
               if (!bad) begin
                  if (trl_ok) begin
                     count_in = trl_cnt;
                  end else begin
                     bad = 1'b1;
                  end
               end
            end
            hcbd_pkg::PH_TR_VAL: begin
               if (ch == hcbd_pkg::CH_CR) begin
                  ctl_in.phase = hcbd_pkg::PH_TR_LF;
               end else if ((ch < hcbd_pkg::CH_SPACE || ch == hcbd_pkg::CH_DEL) &&
                            ch != hcbd_pkg::CH_TAB) begin
                  bad = 1'b1;
               end
               if (!bad) begin
                  if (trl_ok) begin
                     count_in = trl_cnt;
                  end else begin
                     bad = 1'b1;
                  end
               end
            end
            hcbd_pkg::PH_TR_LF: begin
               if (ch == hcbd_pkg::CH_LF && trl_ok) begin
                  count_in     = trl_cnt;
                  ctl_in.phase = hcbd_pkg::PH_END_CR;
               end else begin
                  bad = 1'b1;
               end
            end
            hcbd_pkg::PH_DONE: begin
            end
            default: begin
               ctl_in.phase = hcbd_pkg::PH_ERROR;
            end
         endcase
         if (bad) begin
            ctl_in.phase = hcbd_pkg::PH_ERROR;
         end
      end
   end

   // result
   always_comb begin
      rsp.kind         = hcbd_pkg::K_FRAMING;
      rsp.payload_byte = 8'h00;
      if (!op) begin
         case (ctl.phase)
            hcbd_pkg::PH_START, hcbd_pkg::PH_SIZE, hcbd_pkg::PH_EXT,
            hcbd_pkg::PH_SIZE_LF, hcbd_pkg::PH_END_CR, hcbd_pkg::PH_TR_NAME,
            hcbd_pkg::PH_TR_VAL, hcbd_pkg::PH_TR_LF: begin
            end
            hcbd_pkg::PH_DATA: begin
               rsp.kind         = hcbd_pkg::K_PAYLOAD;
               rsp.payload_byte = ch;
            end
            hcbd_pkg::PH_END_LF: begin
               if (ch == hcbd_pkg::CH_LF && ctl.term) begin
                  rsp.kind = hcbd_pkg::K_COMPLETE;
               end
            end
            hcbd_pkg::PH_DONE: begin
               rsp.kind = hcbd_pkg::K_IGN_DONE;
            end
            default: begin
               rsp.kind = hcbd_pkg::K_IGN_ERR;
            end
         endcase
         if (bad) begin
            rsp.kind         = hcbd_pkg::K_ERROR;
            rsp.payload_byte = 8'h00;
         end
      end
   end

endmodule

@@ hdl/http_chunked_body_decoder.sv @@
// Channel   Ports                              Beat
// input     req_valid/req_ready                req_op, req_data_byte
// result    rsp_valid/rsp_ready                rsp_kind, rsp_payload_byte
// config    csr_wr_en                          csr_wr_data (trailer_limit)
//
// One byte per clock sustained while rsp_ready does not stall; a beat goes
// input register -> result register, so a result shows on rsp_valid once
// its byte has passed both registers. The parser state update is combinational.
// Synchronous reset clears the parser, both valid flags and sets
// trailer_limit to 4096.
// A stall on rsp_ready holds both registers; req_ready drops only when both are full.
module http_chunked_body_decoder #(
   parameter int COUNT_BITS = hcbd_pkg::COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic                  in_valid_ff, in_valid_in;
   logic                  in_op_ff;
   logic [7:0]            in_byte_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   hcbd_pkg::result_type  rsp_ff, rsp_in;
   hcbd_pkg::ctl_type     ctl_ff, ctl_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [15:0]           limit_ff;

   logic out_free;
   logic advance;
   logic req_fire;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign advance     = in_valid_ff && out_free;
   assign req_ready   = !in_valid_ff || out_free;
   assign req_fire    = req_valid && req_ready;
   assign in_valid_in = req_fire || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   hcbd_step #(
      .COUNT_BITS(COUNT_BITS)
   ) u_step (
      .ctl           (ctl_ff),
      .count         (count_ff),
      .trailer_limit (limit_ff),
      .op            (in_op_ff),
      .ch            (in_byte_ff),
      .ctl_in        (ctl_in),
      .count_in      (count_in),
      .rsp           (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ctl_ff.phase <= hcbd_pkg::PH_START;
         ctl_ff.term  <= 1'b0;
         count_ff     <= '0;
         limit_ff     <= hcbd_pkg::TRAILER_LIMIT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            ctl_ff   <= ctl_in;
            count_ff <= count_in;
         end
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_op_ff   <= req_op;
         in_byte_ff <= req_data_byte;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_ff.kind;
   assign rsp_payload_byte = rsp_ff.payload_byte;

   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("processed beat did not reach the result register");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !advance |=> !rsp_valid)
      else $error("taken result still shown");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.phase == hcbd_pkg::PH_ERROR && !(advance && in_op_ff)
      |=> ctl_ff.phase == hcbd_pkg::PH_ERROR)
      else $error("error phase left without restart");

   a_term_sticky: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.term && !(advance && in_op_ff) |=> ctl_ff.term)
      else $error("terminal flag cleared without restart");

endmodule

@@ tb/http_chunked_body_decoder_test.sv @@
`timescale 1ns / 1ps

module http_chunked_body_decoder_test;

   localparam int ITEMS = 1550;
   localparam int STALL_LIMIT = 1000;
   localparam logic [63:0] SIZE_CAP = 64'h1 << 60;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_op = 1'b0;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_payload_byte;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'h0000;

   class chunk_scoreboard;
      hcbd_pkg::result_type pending_results[$];
      logic [15:0]          trailer_limit;
      hcbd_pkg::phase_type  phase;
      logic [63:0]          count;
      logic                 term;
      int                   errors;

      function new();
         trailer_limit = hcbd_pkg::TRAILER_LIMIT_RESET;
         restart();
         errors = 0;
      endfunction

      function void restart();
         phase = hcbd_pkg::PH_START;
         count = 64'd0;
         term = 1'b0;
      endfunction

      function int hex_digit(logic [7:0] ch);
         logic [7:0] lc;
         lc = ch | hcbd_pkg::CH_SPACE;
         if (ch >= 8'h30 && ch <= 8'h39) return int'(ch - 8'h30);
         if (lc >= 8'h61 && lc <= 8'h66) return int'(lc - 8'h61) + 10;
         return -1;
      endfunction

      function bit is_token_char(logic [7:0] ch);
         logic [7:0] lc;
         lc = ch | hcbd_pkg::CH_SPACE;
         if (ch >= 8'h30 && ch <= 8'h39) return 1'b1;
         if (lc >= 8'h61 && lc <= 8'h7A) return 1'b1;
         case (ch)
            8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
            8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: return 1'b1;
            default: return 1'b0;
         endcase
      endfunction

      // trailer byte budget; false once the limit is passed
      function bit count_trailer_byte();
         count = count + 64'd1;
         return count <= {48'd0, trailer_limit};
      endfunction

      // advances the decoder by one accepted beat and queues its result
      function hcbd_pkg::kind_type decode_beat(logic op, logic [7:0] ch);
         hcbd_pkg::result_type r;
         bit bad;
         int hv;
         r.kind = hcbd_pkg::K_FRAMING;
         r.payload_byte = 8'h00;
         bad = 1'b0;
         hv = hex_digit(ch);
         if (op) begin
            restart();
         end else begin
            case (phase)
               hcbd_pkg::PH_START: begin
                  if (hv < 0) bad = 1'b1;
                  else begin
                     count = 64'(hv);
                     phase = hcbd_pkg::PH_SIZE;
                  end
               end
               hcbd_pkg::PH_SIZE: begin
                  if (hv >= 0) begin
                     if (count < SIZE_CAP) count = (count << 4) + 64'(hv);
                     else bad = 1'b1;
                  end else if (ch == hcbd_pkg::CH_CR) begin
                     phase = hcbd_pkg::PH_SIZE_LF;
                  end else if (ch == hcbd_pkg::CH_SEMI) begin
                     phase = hcbd_pkg::PH_EXT;
                  end else begin
                     bad = 1'b1;
                  end
               end
               hcbd_pkg::PH_EXT: begin
                  if (ch == hcbd_pkg::CH_CR) phase = hcbd_pkg::PH_SIZE_LF;
               end
               hcbd_pkg::PH_SIZE_LF: begin
                  if (ch != hcbd_pkg::CH_LF) bad = 1'b1;
                  else if (count != 64'd0) phase = hcbd_pkg::PH_DATA;
                  else begin
                     term = 1'b1;
                     phase = hcbd_pkg::PH_END_CR;
                  end
               end
               hcbd_pkg::PH_DATA: begin
                  r.kind = hcbd_pkg::K_PAYLOAD;
                  r.payload_byte = ch;
                  count = count - 64'd1;
                  if (count == 64'd0) phase = hcbd_pkg::PH_END_CR;
               end
               hcbd_pkg::PH_END_CR: begin
                  if (ch == hcbd_pkg::CH_CR) begin
                     phase = hcbd_pkg::PH_END_LF;
                  end else if (term && is_token_char(ch) && count_trailer_byte()) begin
                     phase = hcbd_pkg::PH_TR_NAME;
                  end else begin
                     bad = 1'b1;
                  end
               end
               hcbd_pkg::PH_END_LF: begin
                  if (ch != hcbd_pkg::CH_LF) bad = 1'b1;
                  else if (!term) phase = hcbd_pkg::PH_START;
                  else begin
                     phase = hcbd_pkg::PH_DONE;
                     r.kind = hcbd_pkg::K_COMPLETE;
                  end
               end
               hcbd_pkg::PH_TR_NAME: begin
                  if (ch == hcbd_pkg::CH_COLON) phase = hcbd_pkg::PH_TR_VAL;
                  else if (!is_token_char(ch)) bad = 1'b1;
                  if (!bad && !count_trailer_byte()) bad = 1'b1;
               end
               hcbd_pkg::PH_TR_VAL: begin
                  if (ch == hcbd_pkg::CH_CR) begin
                     phase = hcbd_pkg::PH_TR_LF;
                  end else if ((ch < hcbd_pkg::CH_SPACE || ch == hcbd_pkg::CH_DEL) &&
                               ch != hcbd_pkg::CH_TAB) begin
                     bad = 1'b1;
                  end
                  if (!bad && !count_trailer_byte()) bad = 1'b1;
               end
               hcbd_pkg::PH_TR_LF: begin
                  if (ch == hcbd_pkg::CH_LF && count_trailer_byte()) phase = hcbd_pkg::PH_END_CR;
                  else bad = 1'b1;
               end
               hcbd_pkg::PH_DONE: r.kind = hcbd_pkg::K_IGN_DONE;
               default: begin
                  r.kind = hcbd_pkg::K_IGN_ERR;
                  phase = hcbd_pkg::PH_ERROR;
               end
            endcase
            if (bad) begin
               phase = hcbd_pkg::PH_ERROR;
               r.kind = hcbd_pkg::K_ERROR;
               r.payload_byte = 8'h00;
            end
         end
         pending_results.push_back(r);
         return r.kind;
      endfunction

      task report_mismatch(string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      task check_result(logic [2:0] kind, logic [7:0] pay);
         hcbd_pkg::result_type exp;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result kind %0d byte %02h with nothing expected",
                                      kind, pay));
            return;
         end
         exp = pending_results.pop_front();
         if (kind !== exp.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", kind, exp.kind));
         if (pay !== exp.payload_byte)
            report_mismatch($sformatf("payload_byte %02h, expected %02h",
                                      pay, exp.payload_byte));
      endtask
   endclass

   chunk_scoreboard sb;

   int  idle_pct = 10;
   int  stall_pct = 10;
   bit  quiet = 1'b0;
   int  stall_left = 0;
   int  idle_cycles = 0;
   int  items_done = 0;
   logic [7:0] msg[$];
   string tchars = "!#$%&'*+-.^_|~0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
   logic [15:0] limit_plan[6] = '{16'd0, 16'hFFFF, 16'd3, 16'd12, 16'd40, 16'd4096};

   http_chunked_body_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready)
         sb.check_result(rsp_kind, rsp_payload_byte);
      if (quiet || stall_left == 0) begin
         rsp_ready <= 1'b1;
         if (!quiet && $urandom_range(99) < stall_pct) stall_left = $urandom_range(6, 1);
      end else begin
         rsp_ready <= 1'b0;
         stall_left--;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic int pick_rate();
      case ($urandom_range(2))
         0: return 0;
         1: return 10;
         default: return 35;
      endcase
   endfunction

   function automatic void put(logic [7:0] b);
      msg.push_back(b);
   endfunction

   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) put(s[i]);
   endfunction

   function automatic void put_crlf();
      put(hcbd_pkg::CH_CR);
      put(hcbd_pkg::CH_LF);
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] d);
      if (d < 4'd10) return 8'h30 + 8'(d);
      return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(d) - 8'd10;
   endfunction

   function automatic void put_size(int unsigned v);
      logic [3:0] digs[$];
      do begin
         digs.push_front(v[3:0]);
         v = v >> 4;
      end while (v != 0);
      if ($urandom_range(3) == 0) repeat ($urandom_range(2, 1)) digs.push_front(4'h0);
      foreach (digs[i]) put(hex_char(digs[i]));
   endfunction

   function automatic void put_ext();
      logic [7:0] b;
      if ($urandom_range(3) == 0) begin
         put(hcbd_pkg::CH_SEMI);
         repeat ($urandom_range(5)) begin
            b = 8'($urandom);
            if (b == hcbd_pkg::CH_CR) b = 8'h2D;
            put(b);
         end
      end
   endfunction

   function automatic logic [7:0] token_char();
      int r;
      r = $urandom_range(tchars.len());
      if (r == tchars.len()) return 8'h60;
      return tchars[r];
   endfunction

   function automatic logic [7:0] value_char();
      int r;
      r = $urandom_range(9);
      if (r == 0) return hcbd_pkg::CH_TAB;
      if (r < 3) return 8'($urandom_range(255, 128));
      return 8'($urandom_range(126, 32));
   endfunction

   function automatic void build_message();
      int unsigned chunks;
      int unsigned sz;
      chunks = $urandom_range(3);
      for (int i = 0; i < chunks; i++) begin
         sz = ($urandom_range(9) == 0) ? $urandom_range(64, 1) : $urandom_range(8, 1);
         put_size(sz);
         put_ext();
         put_crlf();
         repeat (sz) put(8'($urandom));
         put_crlf();
      end
      put_size(0);
      put_ext();
      put_crlf();
      if ($urandom_range(1)) begin
         repeat ($urandom_range(2, 1)) begin
            repeat ($urandom_range(6, 1)) put(token_char());
            put(hcbd_pkg::CH_COLON);
            repeat ($urandom_range(8)) put(value_char());
            put_crlf();
         end
      end
      put_crlf();
      repeat ($urandom_range(2)) put(8'($urandom));
   endfunction

   task automatic send_beat(input logic op, input logic [7:0] b);
      hcbd_pkg::kind_type k;
      if (!quiet && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_data_byte <= b;
      do @(posedge clock); while (req_ready !== 1'b1);
      k = sb.decode_beat(op, b);
      if (k != hcbd_pkg::K_IGN_ERR && k != hcbd_pkg::K_IGN_DONE) items_done++;
   endtask

   // cut >= 0 injects a restart in front of that byte
   task automatic send_msg(input int cut);
      foreach (msg[i]) begin
         if (i == cut) send_beat(1'b1, 8'($urandom));
         send_beat(1'b0, msg[i]);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending_results.size() != 0);
   endtask

   task automatic settle();
      drain();
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(input logic [15:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.trailer_limit = v;
   endtask

   task automatic random_item();
      int pick;
      int cut;
      int idx;
      pick = $urandom_range(99);
      cut = -1;
      msg.delete();
      if (pick < 2) drain();
      if (pick < 75) begin
         build_message();
         if ($urandom_range(4) == 0) begin
            idx = $urandom_range(msg.size() - 1);
            case ($urandom_range(2))
               0: msg[idx] = 8'($urandom);
               1: msg.insert(idx, 8'($urandom));
               default: cut = idx;
            endcase
         end
      end else if (pick < 88) begin
         // size line at the edge of the counter width
         repeat ($urandom_range(3)) put(8'h30);
         put(hex_char(4'($urandom_range(15, 1))));
         repeat (15) put(hex_char(4'($urandom_range(15))));
         if ($urandom_range(1)) begin
            put(hex_char(4'($urandom_range(15))));
            repeat ($urandom_range(2)) put(8'($urandom));
         end else begin
            put_ext();
            put_crlf();
            repeat ($urandom_range(6, 1)) put(8'($urandom));
         end
      end else begin
         repeat ($urandom_range(8, 1)) put(8'($urandom));
      end
      send_beat(1'b1, 8'($urandom));
      send_msg(cut);
   endtask

   initial begin
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: bad start, sticky error, one full message with trailer, ignore after done
      send_beat(1'b1, 8'hFF);
      send_beat(1'b0, 8'h47);
      send_beat(1'b0, 8'h00);
      send_beat(1'b1, 8'h00);
      msg.delete();
      put_text("1;");
      put(8'h80);
      put_crlf();
      put(8'hFF);
      put_crlf();
      put_text("0");
      put_crlf();
      put_text("X:");
      put(hcbd_pkg::CH_TAB);
      put_crlf();
      put_crlf();
      put_text("A");
      send_msg(-1);

      for (int p = 0; p < 7; p++) begin
         if (p > 0) begin
            settle();
            write_limit(p == 5 ? 16'($urandom) : limit_plan[p - 1]);
         end
         quiet = (p == 6);
         idle_pct = quiet ? 0 : pick_rate();
         stall_pct = quiet ? 0 : pick_rate();
         while (items_done < (p + 1) * ITEMS / 7) random_item();
      end

      settle();
      if (sb.errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
